[rtl/cmptmr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmptmr_pkg: shared types and constants of the compare timer
// Register offsets, half-word masks, stream widths and the item and result
// structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package cmptmr_pkg;

  // Stream widths (data fields packed from bit 0, padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;

  // Register map, byte offsets in the window
  localparam logic [7:0] OFS_COUNT_LO = 8'h00;
  localparam logic [7:0] OFS_COUNT_HI = 8'h04;
  localparam logic [7:0] OFS_CMP_LO   = 8'h08;
  localparam logic [7:0] OFS_CMP_HI   = 8'h0C;
  localparam logic [7:0] OFS_CTRL     = 8'h10;

  // Item kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_ACCESS = 1'b1;

  localparam logic [63:0] HIGH_HALF = 64'hFFFF_FFFF_0000_0000;
  localparam logic [63:0] LOW_HALF  = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic        write_enable;
    logic [7:0]  access_offset;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        address_error;
    logic        irq_level;
  } result_t;

  // Replace the low half of a 64-bit register
  function automatic logic [63:0] put_low(input logic [63:0] reg_val, input logic [31:0] v);
    put_low = (reg_val & HIGH_HALF) | {32'd0, v};
  endfunction

  // Replace the high half of a 64-bit register
  function automatic logic [63:0] put_high(input logic [63:0] reg_val, input logic [31:0] v);
    put_high = (reg_val & LOW_HALF) | {v, 32'd0};
  endfunction

endpackage

[rtl/cmptmr_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmptmr_in_stage: input register
// Captures one beat from the slave side and holds it until the register
// file executes it. Accepts a new beat in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module cmptmr_in_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cmptmr_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // access_offset, write_data
  input  logic [cmptmr_pkg::IN_USER_W-1:0]    s_axis_tuser,   // kind, write_enable
  input  logic                                take,
  output logic                                item_vld,
  output cmptmr_pkg::item_t                   item
);

  logic              vld;
  cmptmr_pkg::item_t held;

  assign s_axis_tready = !vld || take;
  assign item_vld      = vld;
  assign item          = held;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_axis_tready) begin
      vld <= s_axis_tvalid;
    end
  end

  // Payload, unpacked from the beat
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      held.kind          <= s_axis_tuser[0];
      held.write_enable  <= s_axis_tuser[1];
      held.access_offset <= s_axis_tdata[7:0];
      held.write_data    <= s_axis_tdata[39:8];
    end
  end

endmodule

[rtl/cmptmr_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmptmr_regs: timer state and access decode
// Holds count, compare value and control word; executes one item per
// cycle while fire is high and produces its result, including the interrupt level after it.
// ----------------------------------------------------------------------------
module cmptmr_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  cmptmr_pkg::item_t      item,
  output cmptmr_pkg::result_t    result
);

  logic [63:0] tick_count, tick_count_next;
  logic [63:0] compare_value, compare_value_next;
  logic [31:0] control_word, control_word_next;
  logic [31:0] rd;
  logic        err;

  // Decode and next state
  always_comb begin
    tick_count_next    = tick_count;
    compare_value_next = compare_value;
    control_word_next  = control_word;
    rd                 = 32'd0;
    err                = 1'b0;
    if (item.kind == cmptmr_pkg::KIND_TICK) begin
      tick_count_next = tick_count + 64'd1;
    end else begin
      unique case (item.access_offset)
        cmptmr_pkg::OFS_COUNT_LO: begin
          if (item.write_enable) tick_count_next = cmptmr_pkg::put_low(tick_count, item.write_data);
          else rd = tick_count[31:0];
        end
        cmptmr_pkg::OFS_COUNT_HI: begin
          if (item.write_enable) tick_count_next = cmptmr_pkg::put_high(tick_count, item.write_data);
          else rd = tick_count[63:32];
        end
        cmptmr_pkg::OFS_CMP_LO: begin
          if (item.write_enable) begin
            compare_value_next = cmptmr_pkg::put_low(compare_value, item.write_data);
          end else begin
            rd = compare_value[31:0];
          end
        end
        cmptmr_pkg::OFS_CMP_HI: begin
          if (item.write_enable) begin
            compare_value_next = cmptmr_pkg::put_high(compare_value, item.write_data);
          end else begin
            rd = compare_value[63:32];
          end
        end
        cmptmr_pkg::OFS_CTRL: begin
          if (item.write_enable) control_word_next = item.write_data;
          else rd = control_word;
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end
  end

  // Result: interrupt level reflects state after this item
  always_comb begin
    result.read_data     = rd;
    result.address_error = err;
    result.irq_level     = control_word_next[0] && (tick_count_next >= compare_value_next);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= 64'd0;
      compare_value <= 64'd0;
      control_word  <= 32'd0;
    end else if (fire) begin
      tick_count    <= tick_count_next;
      compare_value <= compare_value_next;
      control_word  <= control_word_next;
    end
  end

endmodule

[rtl/cmptmr_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmptmr_out_stage: result register
// Holds one result beat for the master side; frees up in the cycle the
// held beat is taken, so a new result can load back to back.
// ----------------------------------------------------------------------------
module cmptmr_out_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  cmptmr_pkg::result_t                 result,
  output logic                                room,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cmptmr_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // read_data, address_error, irq_level
);

  logic                vld;
  cmptmr_pkg::result_t held;

  assign room          = !vld || m_axis_tready;
  assign m_axis_tvalid = vld;
  assign m_axis_tdata  = {6'd0, held.irq_level, held.address_error, held.read_data};

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (room) begin
      vld <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

[rtl/compare_timer_registers.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compare_timer_registers: 64-bit machine timer with compare register
// Each input beat is a tick or a 32-bit register access; each yields one
// result beat with read data, address error and interrupt level.
// ----------------------------------------------------------------------------
// One beat is taken every clock cycle when the master side keeps up. A beat
// is registered on entry, executed against the timer state once the result
// register has room (increment or half-word update plus the 64-bit
// count >= compare check) and its result registered for the master side.
// Throughput is set by the state update, which lets every item see the
// state left by the one before it. Offsets: 0x00/0x04 count low/high, 0x08/0x0C
// compare low/high, 0x10 control (bit 0 enables the interrupt); any other
// offset flags an address error and changes nothing.
module compare_timer_registers (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cmptmr_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // access_offset, write_data
  input  logic [cmptmr_pkg::IN_USER_W-1:0]    s_axis_tuser,   // kind, write_enable
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cmptmr_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // read_data, address_error, irq_level
);

  logic                item_vld;
  cmptmr_pkg::item_t   item;
  cmptmr_pkg::result_t result;
  logic                room;
  logic                fire;

  // Execute when an item is held and the result register has room
  assign fire = item_vld && room;

  cmptmr_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take          (fire),
    .item_vld      (item_vld),
    .item          (item)
  );

  cmptmr_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  cmptmr_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (fire),
    .result        (result),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[rtl/cmptmr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmptmr_checker: port-level checks for the compare timer
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module cmptmr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [cmptmr_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // access_offset, write_data
  input logic [cmptmr_pkg::IN_USER_W-1:0]    s_axis_tuser,   // kind, write_enable
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [cmptmr_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // read_data, address_error, irq_level
);

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ (^s_axis_tdata) ^ (^s_axis_tuser);

  // Nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid right after reset");

  // Input stalls only while a result waits on the master side
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with free result register");

  // An address error never carries read data
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("address error with nonzero read data");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

endmodule

bind compare_timer_registers cmptmr_checker u_cmptmr_checker (.*);
